// File: rtl/ldev_pkg.sv
`timescale 1ns / 1ps

package ldev_pkg;

    // Width of the working degree and step counter (values up to 127).
    localparam int DEG_W = 7;

    // Largest magnitude held by any value of the block.
    localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Rounding constant for the Q2.30 product shift.
    localparam logic [63:0] PT_ROUND = 64'd1 << 29;

    // Fields of one input item.
    typedef struct packed {
        logic [5:0]         degree;
        logic [1:0]         deriv_order;
        logic signed [31:0] point;
    } arg_t;

    // Fields of one result item.
    typedef struct packed {
        logic signed [63:0] value;
        logic               saturated;
    } res_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PX_LO,
        ST_PX_HI,
        ST_PX_FIN,
        ST_T1_LO,
        ST_T1_HI,
        ST_T1_FIN,
        ST_T2_LO,
        ST_T2_HI,
        ST_T2_FIN,
        ST_DIV,
        ST_FINISH
    } state_t;

    // Seed (2k)!/(2^k k!) as an integer, for k up to 4.
    function automatic logic [6:0] seed_of(input logic [2:0] k);
        logic [6:0] s;
        case (k)
            3'd0:    s = 7'd1;
            3'd1:    s = 7'd1;
            3'd2:    s = 7'd3;
            3'd3:    s = 7'd15;
            default: s = 7'd105;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/ldev_mul.sv
`timescale 1ns / 1ps

module ldev_mul
    import ldev_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // Registered unsigned 32 by 32 product, shared by every multiplication.
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/ldev_div.sv
`timescale 1ns / 1ps

module ldev_div
    import ldev_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        dividend,
    input  logic [DEG_W-1:0]   divisor,
    output logic               done,
    output logic [63:0]        quotient
);

    logic [63:0]      quo_reg, quo_next;
    logic [DEG_W-1:0] rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEG_W:0]   trial;
    logic             take;

    // One quotient bit per cycle, restoring division.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        take      = trial >= {1'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[62:0], take};
            rem_next = take ? DEG_W'(trial - {1'b0, divisor}) : trial[DEG_W-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/legendre_derivative_eval.sv
`timescale 1ns / 1ps

// Evaluates the k-th derivative of the Legendre polynomial P_n at a point x.
// Input channel arg/arg_valid/arg_stall carries degree, order and a Q2.30
// point; the result channel res/res_valid/res_stall returns the value in
// Q(63-FRAC_BITS).FRAC_BITS and a flag set when any value was clipped.
// An item is taken when valid is high and stall is low.
// The block works on one item at a time and holds arg_stall high meanwhile.
// Each step of the upward recurrence runs the product, first-term and
// second-term states around the shared 32x32 multiplier, then the
// one-bit-per-cycle divider by (m-k). An item of degree n and order k takes
// n-k steps, and n <= k takes none; the next item can be taken once the
// result has been registered.
// The result sits in an output register; while res_stall is high it holds,
// and the next item may be accepted and worked on behind it, but it cannot
// finish until the waiting result has been taken.
// Reset clears the sequencer and the output valid; nothing else needs it.
module legendre_derivative_eval
    import ldev_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int MAX_ORDER  = 3,
    parameter int FRAC_BITS  = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic arg_valid,
    output logic arg_stall,
    input  arg_t arg,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam logic [DEG_W-1:0] DEG_LIM = DEG_W'(MAX_DEGREE);
    localparam logic [2:0]       ORD_LIM = 3'(MAX_ORDER);

    state_t state_reg, state_next;

    logic [DEG_W-1:0]   n_reg, n_next;
    logic [2:0]         k_reg, k_next;
    logic [DEG_W-1:0]   m_reg, m_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [63:0] cur_reg, cur_next;
    logic signed [63:0] prev_reg, prev_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] t1_reg, t1_next;
    logic [63:0]        lo_reg, lo_next;
    logic [63:0]        num_reg, num_next;
    logic               neg_reg, neg_next;
    logic               sat_reg, sat_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;
    logic               div_go_reg;

    logic [31:0]        mul_a, mul_b, xmag;
    logic [63:0]        prod, quotient;
    logic               div_start, div_done;
    logic [63:0]        cur_mag, prev_mag, t_mag;
    logic [7:0]         c1, c2;
    logic [63:0]        lo_rnd;
    logic [64:0]        px_sum;
    logic               px_ovf, px_neg;
    logic [95:0]        mi_sum;
    logic               mi_ovf;
    logic [64:0]        diff;
    logic [63:0]        t2_val;
    logic [DEG_W-1:0]   divisor;
    logic [DEG_W-1:0]   deg_in;
    logic [2:0]         ord_in;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_of(input logic [63:0] m, input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    ldev_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ldev_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Operands and coefficients of the current step.
    always_comb
    begin
        cur_mag  = mag_of(cur_reg);
        prev_mag = mag_of(prev_reg);
        t_mag    = mag_of(t_reg);
        xmag     = x_reg[31] ? 32'(-x_reg) : 32'(x_reg);
        c1       = 8'({m_reg, 1'b0} - 8'd1);
        c2       = 8'(m_reg) - 8'd1 + 8'(k_reg);
        divisor  = m_reg - DEG_W'(k_reg);
        deg_in   = (DEG_W'(arg.degree) > DEG_LIM) ? DEG_LIM : DEG_W'(arg.degree);
        ord_in   = ({1'b0, arg.deriv_order} > ORD_LIM) ? ORD_LIM : {1'b0, arg.deriv_order};
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PX_LO:
            begin
                mul_a = cur_mag[31:0];
                mul_b = xmag;
            end
            ST_PX_HI:
            begin
                mul_a = cur_mag[63:32];
                mul_b = xmag;
            end
            ST_T1_LO:
            begin
                mul_a = t_mag[31:0];
                mul_b = {24'd0, c1};
            end
            ST_T1_HI:
            begin
                mul_a = t_mag[63:32];
                mul_b = {24'd0, c1};
            end
            ST_T2_LO:
            begin
                mul_a = prev_mag[31:0];
                mul_b = {24'd0, c2};
            end
            ST_T2_HI:
            begin
                mul_a = prev_mag[63:32];
                mul_b = {24'd0, c2};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Combining partial products, clipping and the difference.
    always_comb
    begin
        lo_rnd = (lo_reg + PT_ROUND) >> 30;
        px_sum = {prod[62:0], 2'b00} + {1'b0, lo_rnd};
        px_ovf = (prod[63:61] != 3'd0) || (px_sum > {1'b0, VMAX});
        px_neg = cur_reg[63] ^ x_reg[31];
        mi_sum = {prod, 32'd0} + {32'd0, lo_reg};
        mi_ovf = mi_sum > {32'd0, VMAX};
        t2_val = signed_of(mi_ovf ? VMAX : mi_sum[63:0], prev_reg[63]);
        diff   = {t1_reg[63], t1_reg} - {t2_val[63], t2_val};
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        x_next         = x_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        t_next         = t_reg;
        t1_next        = t1_reg;
        lo_next        = lo_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        div_start      = div_go_reg;
        arg_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                arg_stall = 1'b0;
                if (arg_valid)
                begin
                    n_next     = deg_in;
                    k_next     = ord_in;
                    x_next     = arg.point;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                sat_next  = 1'b0;
                prev_next = '0;
                m_next    = DEG_W'(k_reg) + DEG_W'(1);
                if (n_reg < DEG_W'(k_reg))
                begin
                    cur_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cur_next   = $signed(64'(seed_of(k_reg)) << FRAC_BITS);
                    state_next = (n_reg == DEG_W'(k_reg)) ? ST_FINISH : ST_PX_LO;
                end
            end
            ST_PX_LO:
            begin
                state_next = ST_PX_HI;
            end
            ST_PX_HI:
            begin
                lo_next    = prod;
                state_next = ST_PX_FIN;
            end
            ST_PX_FIN:
            begin
                t_next     = signed_of(px_ovf ? VMAX : px_sum[63:0], px_neg);
                sat_next   = sat_reg | px_ovf;
                state_next = ST_T1_LO;
            end
            ST_T1_LO:
            begin
                state_next = ST_T1_HI;
            end
            ST_T1_HI:
            begin
                lo_next    = prod;
                state_next = ST_T1_FIN;
            end
            ST_T1_FIN:
            begin
                t1_next    = signed_of(mi_ovf ? VMAX : mi_sum[63:0], t_reg[63]);
                sat_next   = sat_reg | mi_ovf;
                state_next = ST_T2_LO;
            end
            ST_T2_LO:
            begin
                state_next = ST_T2_HI;
            end
            ST_T2_HI:
            begin
                lo_next    = prod;
                state_next = ST_T2_FIN;
            end
            ST_T2_FIN:
            begin
                // Clip the difference, then add half the divisor to its magnitude.
                sat_next = sat_reg | mi_ovf;
                if ($signed(diff) > $signed({1'b0, VMAX}))
                begin
                    sat_next = 1'b1;
                    neg_next = 1'b0;
                    num_next = VMAX + 64'(divisor >> 1);
                end
                else if ($signed(diff) < -$signed({1'b0, VMAX}))
                begin
                    sat_next = 1'b1;
                    neg_next = 1'b1;
                    num_next = VMAX + 64'(divisor >> 1);
                end
                else
                begin
                    neg_next = diff[64];
                    num_next = mag_of(diff[63:0]) + 64'(divisor >> 1);
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    prev_next  = cur_reg;
                    cur_next   = signed_of(quotient, neg_reg);
                    m_next     = m_reg + DEG_W'(1);
                    state_next = (m_reg == n_reg) ? ST_FINISH : ST_PX_LO;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next     = 1'b1;
                    res_next.value     = cur_reg;
                    res_next.saturated = sat_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The divider starts on the first cycle of the division state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= (state_reg == ST_T2_FIN);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        m_reg    <= m_next;
        x_reg    <= x_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        t_reg    <= t_next;
        t1_reg   <= t1_next;
        lo_reg   <= lo_next;
        num_reg  <= num_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ldev_pkg::*;

    localparam longint      LIM   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_U = ldev_pkg::VMAX;

    // Scoreboard: predicts each derivative value and holds the expected results in order.
    class deriv_scoreboard;
        res_t expected_vals[$];
        int   mismatches;
        int   results_seen;
        int   sat_seen;
        bit   clipped;

        function logic [63:0] magnitude(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint clip(logic [63:0] m, bit neg);
            if (m > LIM_U)
            begin
                clipped = 1'b1;
                m = LIM_U;
            end
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint add_clip(longint a, longint b);
            if (b > 0 && a > LIM - b)
            begin
                clipped = 1'b1;
                return LIM;
            end
            if (b < 0 && a < -LIM - b)
            begin
                clipped = 1'b1;
                return -LIM;
            end
            return a + b;
        endfunction

        function longint scale_int(longint v, logic [63:0] c);
            logic [63:0] m;
            m = magnitude(v);
            if (c != 0 && m > LIM_U / c)
            begin
                clipped = 1'b1;
                return clip(LIM_U, v < 0);
            end
            return clip(m * c, v < 0);
        endfunction

        // Product with a Q2.30 point, rounded half away from zero.
        function longint scale_point(longint v, longint x);
            logic [63:0] m;
            logic [63:0] xm;
            logic [63:0] hi;
            logic [63:0] lo;
            bit          neg;
            m   = magnitude(v);
            xm  = magnitude(x);
            hi  = (m >> 32) * xm;
            lo  = (m & 64'hFFFF_FFFF) * xm;
            neg = (v < 0) != (x < 0);
            if (hi >= (64'd1 << 61))
            begin
                clipped = 1'b1;
                return clip(LIM_U, neg);
            end
            lo = lo + (64'd1 << 29);
            return clip((hi << 2) + (lo >> 30), neg);
        endfunction

        function longint div_round(longint v, logic [63:0] d);
            return clip((magnitude(v) + d / 2) / d, v < 0);
        endfunction

        function res_t predict(arg_t a);
            res_t   r;
            int     n;
            int     k;
            longint x;
            longint prev;
            longint cur;
            longint t1;
            longint t2;
            longint seed;
            n = a.degree;
            k = a.deriv_order;
            x = longint'(a.point);
            if (n > 32)
                n = 32;
            clipped = 1'b0;
            r.value = '0;
            r.saturated = 1'b0;
            if (n < k)
                return r;
            seed = 1;
            for (int i = 1; i <= k; i++)
                seed = seed * (2 * i - 1);
            cur  = seed <<< 32;
            prev = 0;
            for (int m = k + 1; m <= n; m++)
            begin
                t1   = scale_int(scale_point(cur, x), 64'(2 * m - 1));
                t2   = scale_int(prev, 64'(m - 1 + k));
                t1   = add_clip(t1, -t2);
                prev = cur;
                cur  = div_round(t1, 64'(m - k));
            end
            r.value = cur;
            r.saturated = clipped;
            return r;
        endfunction

        function void note_arg(arg_t a);
            expected_vals.push_back(predict(a));
        endfunction

        function void check_res(res_t got);
            res_t want;
            results_seen++;
            if (expected_vals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d saturated %0b", got.value,
                             got.saturated);
                return;
            end
            want = expected_vals.pop_front();
            if (got.saturated)
                sat_seen++;
            if (got.value !== want.value || got.saturated !== want.saturated)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: value %0d (want %0d), saturated %0b (want %0b)",
                             got.value, want.value, got.saturated, want.saturated);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic arg_valid;
    logic arg_stall;
    arg_t arg;
    logic res_valid;
    logic res_stall;
    res_t res;

    deriv_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int items_sent;

    legendre_derivative_eval dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .arg       (arg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Free-running clock.
    always #6 clk = ~clk;

    // Receiver: checks each taken result, then picks the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_res(res);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offers one item and waits until the block takes it.
    task automatic send_arg(arg_t a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            arg_valid <= 1'b0;
            @(posedge clk);
        end
        arg_valid <= 1'b1;
        arg <= a;
        @(posedge clk);
        while (arg_stall)
            @(posedge clk);
        board.note_arg(a);
        items_sent++;
    endtask

    // Drops valid; called after the current item has been taken.
    task automatic go_quiet();
        arg_valid <= 1'b0;
    endtask

    function automatic arg_t make_arg(int n, int k, logic [31:0] x);
        arg_t a;
        a.degree = 6'(n);
        a.deriv_order = 2'(k);
        a.point = x;
        return a;
    endfunction

    // Random item: mostly low degrees, points mostly within [-1,1].
    function automatic arg_t random_arg();
        int          sel;
        int          n;
        logic [31:0] x;
        sel = $urandom_range(99);
        if (sel < 70)
            n = $urandom_range(8);
        else if (sel < 95)
            n = $urandom_range(20, 9);
        else
            n = $urandom_range(63, 21);
        if ($urandom_range(99) < 80)
            x = 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
        else
            x = $urandom;
        return make_arg(n, $urandom_range(3), x);
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_arg(random_arg());
    endtask

    // Main sequence.
    initial
    begin
        int drain_wait;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        arg_valid = 1'b0;
        arg = '0;
        res_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, clamping, degree below and equal to order, overflow.
        send_arg(make_arg(0, 0, 32'h4000_0000));
        send_arg(make_arg(1, 0, 32'h4000_0000));
        send_arg(make_arg(2, 0, 32'hC000_0000));
        send_arg(make_arg(32, 0, 32'h4000_0000));
        send_arg(make_arg(32, 0, 32'hC000_0000));
        send_arg(make_arg(63, 0, 32'h2000_0000));
        send_arg(make_arg(40, 1, 32'h0000_0000));
        send_arg(make_arg(0, 3, 32'h4000_0000));
        send_arg(make_arg(2, 3, 32'hFFFF_FFFF));
        send_arg(make_arg(1, 1, 32'h1234_5678));
        send_arg(make_arg(2, 2, 32'h0000_0001));
        send_arg(make_arg(3, 3, 32'hC000_0000));
        send_arg(make_arg(5, 3, 32'h4000_0000));
        send_arg(make_arg(32, 3, 32'h4000_0000));
        send_arg(make_arg(32, 3, 32'h8000_0000));
        send_arg(make_arg(32, 2, 32'h7FFF_FFFF));
        send_arg(make_arg(20, 0, 32'h8000_0000));
        send_arg(make_arg(7, 1, 32'h2000_0000));
        send_arg(make_arg(9, 2, 32'hE000_0000));
        send_arg(make_arg(63, 3, 32'hBFFF_FFFF));

        // Random phases with different idling on each side.
        random_phase(280, 0, 0);
        random_phase(280, 50, 0);
        random_phase(280, 0, 50);
        random_phase(280, 15, 15);

        // Long hold-off at the output while items keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 6000;
        repeat (6)
            send_arg(make_arg($urandom_range(3), $urandom_range(3), $urandom));
        random_phase(20, 0, 0);
        go_quiet();

        // Drain: wait for every expected result, then a latency margin.
        drain_wait = 0;
        while (board.expected_vals.size() != 0 && drain_wait < 200000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (3000) @(posedge clk);

        $display("Sent %0d items (degrees 0..63, orders 0..3, points over full Q2.30);",
                 items_sent);
        $display("checked %0d results, %0d saturated, %0d mismatches.",
                 board.results_seen, board.sat_seen, board.mismatches);
        if (board.mismatches == 0 && board.expected_vals.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(64'd12 * 64'd20_000_000);
        $display("timeout");
        $display("testbench: done, errors");
        $finish;
    end

endmodule
